/* hw/rtl/orientation_packet_to_quaternion_top_assert.svh */
// assertion macros for the orientation packet to quaternion block
// used by the top level only; expects i_clk and i_rst_n in scope
`ifndef ORIENTATION_PACKET_TO_QUATERNION_TOP_ASSERT_SVH
`define ORIENTATION_PACKET_TO_QUATERNION_TOP_ASSERT_SVH

// condition must hold at every edge out of reset
`define OPQ_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("opq assertion failed");

// antecedent implies consequent in the same cycle
`define OPQ_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("opq assertion failed");

`endif

/* hw/rtl/opq_pkg.sv */
// shared types, constants and elaboration-time functions for the
// orientation packet to quaternion block; no dependencies
`timescale 1ns / 1ps

package opq_pkg;

    localparam int DEF_ANGLE_WIDTH   = 16;
    localparam int DEF_CORDIC_STAGES = 14;

    // width of the q30 cordic and product datapath
    localparam int XW = 33;

    localparam logic [7:0] ORIENT_ONLY    = 8'd2;
    localparam logic [7:0] ORIENT_AND_RAW = 8'd3;

    localparam logic signed [XW-1:0] GAIN_Q30 = 33'sd652032874;
    localparam int UNIT_Q14 = 16384;

    // control that travels with each item
    typedef struct packed {
        logic valid;
        logic ok;
    } t_ctl;

    // unsigned 64-bit quotient by shift and subtract
    function automatic longint unsigned udiv64(input longint unsigned n,
                                               input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in q60, i >= 1
    function automatic longint unsigned atan_pow2_q60(input int i);
        longint unsigned p;
        longint unsigned sum;
        longint unsigned term;
        p   = 64'd1 << (60 - i);
        sum = 64'd0;
        for (int k = 0; k < 64; k++) begin
            if (p != 64'd0) begin
                term = udiv64(p, 64'(2 * k + 1));
                if (k % 2 == 1) sum = sum - term;
                else sum = sum + term;
                p = p >> (2 * i);
            end
        end
        return sum;
    endfunction

    // atan(1/3) in q60
    function automatic longint unsigned atan_third_q60();
        longint unsigned p;
        longint unsigned sum;
        longint unsigned term;
        p   = (64'd1 << 60) / 3;
        sum = 64'd0;
        for (int k = 0; k < 64; k++) begin
            if (p != 64'd0) begin
                term = udiv64(p, 64'(2 * k + 1));
                if (k % 2 == 1) sum = sum - term;
                else sum = sum + term;
                p = udiv64(p, 64'd9);
            end
        end
        return sum;
    endfunction

    // round half up from q60 to af fraction bits
    function automatic longint q60_round(input longint unsigned v, input int af);
        longint unsigned sh;
        sh = longint'(60 - af);
        return longint'((v + (64'd1 << (sh - 1))) >> sh);
    endfunction

    // cordic step angle; step zero is pi/4 from machin-like sum
    function automatic longint atan_angle(input int i, input int af);
        if (i == 0) return q60_round(atan_pow2_q60(1) + atan_third_q60(), af);
        return q60_round(atan_pow2_q60(i), af);
    endfunction

    function automatic longint pi_angle(input int af);
        return q60_round(64'd4 * (atan_pow2_q60(1) + atan_third_q60()), af);
    endfunction

    // q30 by q30 product, floor back to q30
    function automatic logic signed [XW-1:0] mul30(input logic signed [XW-1:0] a,
                                                   input logic signed [XW-1:0] b);
        logic signed [2*XW-1:0] p;
        p = a * b;
        return p[XW+29:30];
    endfunction

    // round q30 to q14 and saturate to plus or minus one
    function automatic logic signed [15:0] to_q14(input logic signed [XW:0] v);
        logic signed [XW:0] t;
        t = (v + (XW+1)'(32768)) >>> 16;
        if (t > (XW+1)'(UNIT_Q14)) return 16'sd16384;
        if (t < -(XW+1)'(UNIT_Q14)) return -16'sd16384;
        return t[15:0];
    endfunction

endpackage

/* hw/rtl/opq_cordic.sv */
// three-lane rotation cordic, one register stage per iteration
// depends on opq_pkg
`timescale 1ns / 1ps

module opq_cordic #(
    parameter int AF     = 13,
    parameter int AW     = 18,
    parameter int STAGES = 14
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  opq_pkg::t_ctl                   i_ctl,
    input  logic signed [AW-1:0]            i_h   [3],
    input  logic                            i_neg [3],
    output opq_pkg::t_ctl                   o_ctl,
    output logic signed [opq_pkg::XW-1:0]   o_cos [3],
    output logic signed [opq_pkg::XW-1:0]   o_sin [3]
);
    import opq_pkg::*;

    logic signed [XW-1:0] x   [STAGES+1][3];
    logic signed [XW-1:0] y   [STAGES+1][3];
    logic signed [AW-1:0] z   [STAGES+1][3];
    logic                 neg [STAGES+1][3];
    t_ctl                 ctl [STAGES+1];

    // stage zero inputs
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            x[0][l]   = GAIN_Q30;
            y[0][l]   = '0;
            z[0][l]   = i_h[l];
            neg[0][l] = i_neg[l];
        end
        ctl[0] = i_ctl;
    end

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        localparam logic signed [AW-1:0] ATAN_S = AW'(atan_angle(s, AF));

        // one micro-rotation per lane
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < 3; l++) begin
                    if (z[s][l] >= 0) begin
                        x[s+1][l] <= x[s][l] - (y[s][l] >>> s);
                        y[s+1][l] <= y[s][l] + (x[s][l] >>> s);
                        z[s+1][l] <= z[s][l] - ATAN_S;
                    end else begin
                        x[s+1][l] <= x[s][l] + (y[s][l] >>> s);
                        y[s+1][l] <= y[s][l] - (x[s][l] >>> s);
                        z[s+1][l] <= z[s][l] + ATAN_S;
                    end
                    neg[s+1][l] <= neg[s][l];
                end
            end
        end

        // control travels with the lanes
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                ctl[s+1] <= '0;
            end else if (i_en) begin
                ctl[s+1] <= ctl[s];
            end
        end
    end

    // undo range fold
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            o_cos[l] = neg[STAGES][l] ? -x[STAGES][l] : x[STAGES][l];
            o_sin[l] = neg[STAGES][l] ? -y[STAGES][l] : y[STAGES][l];
        end
        o_ctl = ctl[STAGES];
    end

endmodule

/* hw/rtl/opq_quat.sv */
// quaternion product pipeline: pair products, triple products, round and saturate
// depends on opq_pkg
`timescale 1ns / 1ps

module opq_quat (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  opq_pkg::t_ctl                   i_ctl,
    input  logic signed [opq_pkg::XW-1:0]   i_cos [3],
    input  logic signed [opq_pkg::XW-1:0]   i_sin [3],
    output logic                            o_valid,
    output logic                            o_result_valid,
    output logic signed [15:0]              o_quat_w,
    output logic signed [15:0]              o_quat_x,
    output logic signed [15:0]              o_quat_y,
    output logic signed [15:0]              o_quat_z
);
    import opq_pkg::*;

    t_ctl                 r_ctl_a, r_ctl_b, r_ctl_c;
    logic signed [XW-1:0] r_c1c2, r_s1s2, r_s1c2, r_c1s2, r_c3, r_s3;
    logic signed [XW-1:0] r_p [8];

    // control line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_a <= '0;
            r_ctl_b <= '0;
            r_ctl_c <= '0;
        end else if (i_en) begin
            r_ctl_a <= i_ctl;
            r_ctl_b <= r_ctl_a;
            r_ctl_c <= r_ctl_b;
        end
    end

    // yaw-pitch pair products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1c2 <= mul30(i_cos[0], i_cos[1]);
            r_s1s2 <= mul30(i_sin[0], i_sin[1]);
            r_s1c2 <= mul30(i_sin[0], i_cos[1]);
            r_c1s2 <= mul30(i_cos[0], i_sin[1]);
            r_c3   <= i_cos[2];
            r_s3   <= i_sin[2];
        end
    end

    // products with roll terms
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= mul30(r_c1c2, r_c3);
            r_p[1] <= mul30(r_s1s2, r_s3);
            r_p[2] <= mul30(r_c1c2, r_s3);
            r_p[3] <= mul30(r_s1s2, r_c3);
            r_p[4] <= mul30(r_s1c2, r_c3);
            r_p[5] <= mul30(r_c1s2, r_s3);
            r_p[6] <= mul30(r_c1s2, r_c3);
            r_p[7] <= mul30(r_s1c2, r_s3);
        end
    end

    // combine, round, saturate; rejected packets give zeros
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_result_valid <= r_ctl_b.ok;
            if (r_ctl_b.ok) begin
                o_quat_w <= to_q14((XW+1)'(r_p[0]) - (XW+1)'(r_p[1]));
                o_quat_x <= to_q14((XW+1)'(r_p[2]) + (XW+1)'(r_p[3]));
                o_quat_y <= to_q14((XW+1)'(r_p[4]) + (XW+1)'(r_p[5]));
                o_quat_z <= to_q14((XW+1)'(r_p[6]) - (XW+1)'(r_p[7]));
            end else begin
                o_quat_w <= '0;
                o_quat_x <= '0;
                o_quat_y <= '0;
                o_quat_z <= '0;
            end
        end
    end

    assign o_valid = r_ctl_c.valid;

endmodule

/* hw/rtl/orientation_packet_to_quaternion_top.sv */
// top level of the orientation packet to quaternion block
// depends on opq_pkg, opq_cordic, opq_quat and the assertion header
`timescale 1ns / 1ps

// Turns one orientation packet per cycle into a Q1.14 quaternion. A packet is
// taken every clock while the output is not stalled. The pipeline has one entry
// stage (channel check, triple select, half angle and range fold), one register
// per CORDIC iteration, two multiplier stages and one round/saturate stage that
// is also the output register. A stall at the output holds the whole pipeline.
// Packets with the wrong channel or flags other than orientation-only /
// orientation-plus-raw still give an item, with result_valid low and all
// components zero. The user must write the wanted channel through the config
// port only while no item is in flight; the block itself does not enforce this.

module orientation_packet_to_quaternion_top #(
    parameter int ANGLE_WIDTH   = opq_pkg::DEF_ANGLE_WIDTH,
    parameter int CORDIC_STAGES = opq_pkg::DEF_CORDIC_STAGES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_packet_channel,
    input  logic [7:0]         i_packet_flags,
    input  logic signed [15:0] i_first_yaw,
    input  logic signed [15:0] i_first_pitch,
    input  logic signed [15:0] i_first_roll,
    input  logic signed [15:0] i_late_yaw,
    input  logic signed [15:0] i_late_pitch,
    input  logic signed [15:0] i_late_roll,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_result_valid,
    output logic signed [15:0] o_quat_w,
    output logic signed [15:0] o_quat_x,
    output logic signed [15:0] o_quat_y,
    output logic signed [15:0] o_quat_z,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data
);
    import opq_pkg::*;

    localparam int AF  = ANGLE_WIDTH - 3;
    localparam int SHL = (AF >= 13) ? AF - 13 : 0;
    localparam int SHR = (AF < 13) ? 13 - AF : 0;
    localparam int AW  = 16 + SHL + 2;

    localparam longint PI_L = pi_angle(AF);
    localparam logic signed [AW-1:0] PI_A      = AW'(PI_L);
    localparam logic signed [AW-1:0] HALF_PI_A = AW'(PI_L / 2);

    logic [7:0]           r_wanted_channel;
    logic                 en;
    t_ctl                 n_ctl, r_ctl;
    logic signed [15:0]   raw   [3];
    logic signed [AW-1:0] n_h   [3];
    logic signed [AW-1:0] r_h   [3];
    logic                 n_neg [3];
    logic                 r_neg [3];
    t_ctl                 cor_ctl;
    logic signed [XW-1:0] cor_cos [3];
    logic signed [XW-1:0] cor_sin [3];

    // config register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted_channel <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_wanted_channel <= i_cfg_data;
        end
    end

    // whole pipeline holds while the output item waits
    assign en      = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    // entry: packet check, triple select, half angle, range fold
    always_comb begin
        n_ctl.valid = i_valid;
        n_ctl.ok    = (i_packet_channel == r_wanted_channel)
                   && (i_packet_flags == ORIENT_ONLY || i_packet_flags == ORIENT_AND_RAW);
        if (i_packet_flags == ORIENT_AND_RAW) begin
            raw[0] = i_late_yaw;
            raw[1] = i_late_pitch;
            raw[2] = i_late_roll;
        end else begin
            raw[0] = i_first_yaw;
            raw[1] = i_first_pitch;
            raw[2] = i_first_roll;
        end
        for (int l = 0; l < 3; l++) begin
            if (AF >= 13) n_h[l] = AW'(raw[l]) <<< SHL;
            else n_h[l] = AW'(raw[l] >>> SHR);
            n_neg[l] = 1'b0;
            if (n_h[l] > HALF_PI_A) begin
                n_h[l]   = n_h[l] - PI_A;
                n_neg[l] = 1'b1;
            end else if (n_h[l] < -HALF_PI_A) begin
                n_h[l]   = n_h[l] + PI_A;
                n_neg[l] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (en) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h   <= n_h;
            r_neg <= n_neg;
        end
    end

    opq_cordic #(
        .AF     (AF),
        .AW     (AW),
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (r_ctl),
        .i_h     (r_h),
        .i_neg   (r_neg),
        .o_ctl   (cor_ctl),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin)
    );

    opq_quat u_quat (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_ctl          (cor_ctl),
        .i_cos          (cor_cos),
        .i_sin          (cor_sin),
        .o_valid        (o_valid),
        .o_result_valid (o_result_valid),
        .o_quat_w       (o_quat_w),
        .o_quat_x       (o_quat_x),
        .o_quat_y       (o_quat_y),
        .o_quat_z       (o_quat_z)
    );

`include "orientation_packet_to_quaternion_top_assert.svh"

    // upstream is only held back by a waiting result
    `OPQ_ASSERT_IMPLIES(a_stall_needs_result, o_stall, o_valid && i_stall)

    // rejected packets come out as zeros
    `OPQ_ASSERT_IMPLIES(a_reject_zero, o_valid && !o_result_valid,
        o_quat_w == 16'sd0 && o_quat_x == 16'sd0 && o_quat_y == 16'sd0 && o_quat_z == 16'sd0)

    // w and z components stay within plus or minus one
    `OPQ_ASSERT_IMPLIES(a_saturated, o_valid,
        o_quat_w <= 16'sd16384 && o_quat_w >= -16'sd16384 &&
        o_quat_z <= 16'sd16384 && o_quat_z >= -16'sd16384)

endmodule

/* verif/tb_top.sv */
// self-checking bench for orientation_packet_to_quaternion_top
// depends on opq_pkg and the block's rtl; cordic quaternion predictor inside
`timescale 1ns / 1ps

module tb_top;
    import opq_pkg::*;

    localparam int STAGES   = DEF_CORDIC_STAGES;
    localparam int LATENCY  = STAGES + 4;
    localparam int WD_LIMIT = 5000;

    typedef struct {
        logic [7:0]         chan;
        logic [7:0]         flags;
        logic signed [15:0] ang [6];
    } t_packet;

    typedef struct {
        logic               ok;
        logic signed [15:0] w, x, y, z;
    } t_quat;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       i_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [7:0] i_cfg_data = 8'd0;
    logic       o_stall, o_valid, o_result_valid, o_cfg_ready;
    logic signed [15:0] o_quat_w, o_quat_x, o_quat_y, o_quat_z;
    t_packet    cur;

    t_packet    pending [$];
    t_quat      quat_due [$];
    logic [7:0] want_ch = 8'd0;
    longint     atan_q [STAGES];
    longint     pi_q;
    bit         took_in = 1'b0;
    bit         quiet = 1'b0;
    bit         hold_req = 1'b0;
    int         hold_left = 0;
    int         errors = 0;
    int         n_in = 0, n_out = 0, n_ok = 0;
    int         idle_cycles = 0;

    initial begin
        cur.chan = 8'd0;
        cur.flags = 8'd0;
        foreach (cur.ang[k]) cur.ang[k] = 16'sd0;
    end

    orientation_packet_to_quaternion_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_packet_channel(cur.chan), .i_packet_flags(cur.flags),
        .i_first_yaw(cur.ang[0]), .i_first_pitch(cur.ang[1]), .i_first_roll(cur.ang[2]),
        .i_late_yaw(cur.ang[3]), .i_late_pitch(cur.ang[4]), .i_late_roll(cur.ang[5]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_result_valid(o_result_valid),
        .o_quat_w(o_quat_w), .o_quat_x(o_quat_x), .o_quat_y(o_quat_y), .o_quat_z(o_quat_z),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // arctangent of 1/n in q60 by power series
    function automatic longint unsigned arctan_recip(longint unsigned n);
        longint unsigned p, acc;
        int k;
        p = (64'd1 << 60) / n;
        acc = 0;
        k = 0;
        while (p != 0) begin
            if (k % 2 == 1) acc = acc - p / (2 * k + 1);
            else acc = acc + p / (2 * k + 1);
            p = p / (n * n);
            k++;
        end
        return acc;
    endfunction

    // q60 to q13 angle, rounding half up
    function automatic longint to_angle(longint unsigned v);
        return longint'((v + (64'd1 << 46)) >> 47);
    endfunction

    // half-angle cosine and sine in q30
    task automatic half_trig(input logic signed [15:0] raw, output longint c, output longint s);
        longint h, xv, yv, dx, dy;
        bit flip;
        h = longint'(raw);
        flip = 0;
        xv = 652032874;
        yv = 0;
        if (h > pi_q / 2) begin
            h -= pi_q;
            flip = 1;
        end else if (h < -(pi_q / 2)) begin
            h += pi_q;
            flip = 1;
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (h >= 0) begin
                xv -= dx; yv += dy; h -= atan_q[i];
            end else begin
                xv += dx; yv -= dy; h += atan_q[i];
            end
        end
        c = flip ? -xv : xv;
        s = flip ? -yv : yv;
    endtask

    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic logic signed [15:0] round_q14(longint v);
        longint r;
        r = (v + 32768) >>> 16;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[15:0];
    endfunction

    // expected quaternion for one packet
    task automatic predict_quat(input t_packet p, output t_quat q);
        longint c1, s1, c2, s2, c3, s3, cc, ss, sc, cs;
        int b;
        q = '{ok: 1'b0, w: 16'sd0, x: 16'sd0, y: 16'sd0, z: 16'sd0};
        if (p.chan == want_ch && (p.flags == ORIENT_ONLY || p.flags == ORIENT_AND_RAW)) begin
            b = (p.flags == ORIENT_ONLY) ? 0 : 3;
            half_trig(p.ang[b], c1, s1);
            half_trig(p.ang[b+1], c2, s2);
            half_trig(p.ang[b+2], c3, s3);
            cc = qmul(c1, c2);
            ss = qmul(s1, s2);
            sc = qmul(s1, c2);
            cs = qmul(c1, s2);
            q.ok = 1'b1;
            q.w = round_q14(qmul(cc, c3) - qmul(ss, s3));
            q.x = round_q14(qmul(cc, s3) + qmul(ss, c3));
            q.y = round_q14(qmul(sc, c3) + qmul(cs, s3));
            q.z = round_q14(qmul(cs, c3) - qmul(sc, s3));
        end
    endtask

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("[%0t] error: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // input and output acceptance, prediction and compare
    always @(posedge i_clk) begin
        t_quat q, e;
        took_in = i_rst_n && i_valid && !o_stall;
        if (took_in) begin
            predict_quat(cur, q);
            quat_due.push_back(q);
            n_in++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            n_out++;
            if (quat_due.size() == 0) begin
                report("unexpected item", 1, 0);
            end else begin
                e = quat_due.pop_front();
                if (e.ok) n_ok++;
                if (o_result_valid !== e.ok)
                    report("result_valid", int'(o_result_valid), int'(e.ok));
                if (o_quat_w !== e.w) report("quat_w", int'(o_quat_w), int'(e.w));
                if (o_quat_x !== e.x) report("quat_x", int'(o_quat_x), int'(e.x));
                if (o_quat_y !== e.y) report("quat_y", int'(o_quat_y), int'(e.y));
                if (o_quat_z !== e.z) report("quat_z", int'(o_quat_z), int'(e.z));
            end
        end
        if (took_in || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WD_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WD_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // packet driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || took_in)) begin
            if (pending.size() > 0 && (quiet || $urandom_range(0, 99) >= 10)) begin
                i_valid <= 1'b1;
                cur <= pending.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result receiver with random and long stalls
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !quiet && ($urandom_range(0, 99) < 10);
        end
    end

    function automatic t_packet make_packet(logic [7:0] ch, logic [7:0] fl);
        t_packet p;
        p.chan = ch;
        p.flags = fl;
        foreach (p.ang[k]) begin
            case ($urandom_range(0, 9))
                0: p.ang[k] = 16'sh7fff;
                1: p.ang[k] = -16'sh8000;
                2: p.ang[k] = 16'sd0;
                3: p.ang[k] = 16'($urandom_range(0, 12868) - 6434);
                default: p.ang[k] = 16'($urandom());
            endcase
        end
        return p;
    endfunction

    // mostly well-formed packets on the wanted channel, some noise
    task automatic queue_random(int n);
        logic [7:0] ch, fl;
        for (int i = 0; i < n; i++) begin
            ch = want_ch;
            fl = $urandom_range(0, 1) ? ORIENT_ONLY : ORIENT_AND_RAW;
            if ($urandom_range(0, 99) < 12) ch = 8'($urandom());
            if ($urandom_range(0, 99) < 12) fl = 8'($urandom());
            pending.push_back(make_packet(ch, fl));
        end
    endtask

    task automatic queue_directed();
        t_packet p;
        logic [7:0] fl_list [6] = '{ORIENT_ONLY, ORIENT_AND_RAW, 8'd0, 8'd1, 8'd255, 8'd6};
        logic signed [15:0] edges [5] = '{16'sh7fff, -16'sh8000, 16'sd0, 16'sd6434, -16'sd6434};
        foreach (edges[e]) begin
            p.chan = want_ch;
            p.flags = ORIENT_ONLY;
            foreach (p.ang[k]) p.ang[k] = edges[(e + k) % 5];
            pending.push_back(p);
            p.flags = ORIENT_AND_RAW;
            pending.push_back(p);
        end
        foreach (fl_list[f]) pending.push_back(make_packet(want_ch, fl_list[f]));
        pending.push_back(make_packet(8'd255, ORIENT_ONLY));
        pending.push_back(make_packet(8'd1, ORIENT_AND_RAW));
        pending.push_back(make_packet(8'd128, 8'd255));
    endtask

    // hold the sender until every expected item is back
    task automatic drain();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending.size() > 0 || i_valid || quat_due.size() > 0);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_channel(logic [7:0] v);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        want_ch = v;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // stimulus phases
    initial begin
        logic [7:0] chan_plan [4] = '{8'd255, 8'd0, 8'h5a, 8'h00};
        for (int i = 0; i < STAGES; i++)
            atan_q[i] = (i == 0) ? to_angle(arctan_recip(2) + arctan_recip(3))
                                 : to_angle(arctan_recip(64'd1 << i));
        pi_q = to_angle(4 * (arctan_recip(2) + arctan_recip(3)));
        chan_plan[3] = 8'($urandom());
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        queue_directed();
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            write_channel(chan_plan[ph]);
            quiet = (ph == 1);
            queue_random(320);
            if (ph == 0) begin
                @(posedge i_clk);
                hold_req = 1'b1;
            end
            drain();
        end

        $display("run covered %0d packets, %0d results, %0d valid quaternions", n_in, n_out, n_ok);
        $display("channel settings 0, 255, 0x5a, %0d; long output hold and no-idle phase", want_ch);
        if (errors == 0 && quat_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d items outstanding", errors, quat_due.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* orientation_packet_to_quaternion_top.f */
+incdir+hw/rtl
hw/rtl/opq_pkg.sv
hw/rtl/opq_cordic.sv
hw/rtl/opq_quat.sv
hw/rtl/orientation_packet_to_quaternion_top.sv
verif/tb_top.sv
